### hw/rtl/bounded_list_engine_core_defines.svh
// assertion macros shared by the rtl
`ifndef BOUNDED_LIST_ENGINE_CORE_DEFINES_SVH
`define BOUNDED_LIST_ENGINE_CORE_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define BLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define BLE_ASSERT_IMPL(label, ante, cons, msg) \
    `BLE_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define BLE_ASSERT_NEXT(label, ante, cons, msg) \
    `BLE_ASSERT(label, (ante) |=> (cons), msg)

`endif

### hw/rtl/ble_pkg.sv
package ble_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        ACT_INSERT    = 3'd0,
        ACT_DEL_FRONT = 3'd1,
        ACT_DEL_BACK  = 3'd2,
        ACT_DEL_POS   = 3'd3,
        ACT_DISPLAY   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_SHIFT = 2'd2,
        CELL_WRAP  = 2'd3
    } t_cell_op;

endpackage

### hw/rtl/bounded_list_engine_core.sv
// an accepted request's result is registered for the next cycle; display first enters its state, then sends entries
// insert and delete requests may follow back to back while the output is not stalled
// display sends one entry per cycle while the output is not stalled, and new requests wait until it ends
// delete at position closes the gap by shifting the cells above it
// reset: entry count cleared, control idle, output invalid; cell contents undefined
`include "bounded_list_engine_core_defines.svh"

module bounded_list_engine_core
    import ble_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [2:0]               i_action,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [7:0]               i_position,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_value_res,
    output logic [1:0]               o_status,
    output logic                     o_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DISP = 2'b10
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_disp, n_disp;
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_value_res, n_value_res;
    t_status                  r_status, n_status;
    logic                     r_last, n_last;

    t_cell_op                 w_op   [CAPACITY];
    logic signed [DATA_W-1:0] w_data [CAPACITY];
    logic signed [DATA_W-1:0] w_next [CAPACITY];

    logic          out_free;
    logic          accept;
    logic          disp_last;
    logic [IW-1:0] del_idx;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;
    assign disp_last  = (CW'(r_disp + 1'b1) == r_count);

    always_comb begin
        case (t_action'(i_action))
            ACT_DEL_BACK: del_idx = IW'(r_count - 1'b1);
            ACT_DEL_POS:  del_idx = IW'(i_position - 8'd1);
            default:      del_idx = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_disp      = r_disp;
        n_out_valid = r_out_valid && i_out_stall;
        n_value_res = r_value_res;
        n_status    = r_status;
        n_last      = r_last;
        for (int i = 0; i < CAPACITY; i++) begin
            w_op[i] = CELL_HOLD;
        end

        if (r_state == S_IDLE) begin
            if (accept) begin
                case (t_action'(i_action))
                    ACT_INSERT: begin
                        n_out_valid = 1'b1;
                        n_value_res = '0;
                        n_last      = 1'b1;
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status = ST_OK;
                            n_count  = r_count + 1'b1;
                            for (int i = 0; i < CAPACITY; i++) begin
                                if (CW'(i) == r_count) begin
                                    w_op[i] = CELL_LOAD;
                                end
                            end
                        end
                    end
                    ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_POS: begin
                        n_out_valid = 1'b1;
                        n_value_res = '0;
                        n_last      = 1'b1;
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else if ((t_action'(i_action) == ACT_DEL_POS) &&
                                     ((i_position == 8'd0) ||
                                      ({1'b0, i_position} > 9'(r_count)))) begin
                            n_status = ST_BADPOS;
                        end else begin
                            n_status    = ST_OK;
                            n_value_res = w_data[del_idx];
                            n_count     = r_count - 1'b1;
                            for (int i = 0; i < CAPACITY; i++) begin
                                if ((IW'(i) >= del_idx) && (CW'(i + 1) < r_count)) begin
                                    w_op[i] = CELL_SHIFT;
                                end
                            end
                        end
                    end
                    ACT_DISPLAY: begin
                        if (r_count == '0) begin
                            n_out_valid = 1'b1;
                            n_value_res = '0;
                            n_status    = ST_EMPTY;
                            n_last      = 1'b1;
                        end else begin
                            n_state = S_DISP;
                            n_disp  = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else if (out_free) begin
            n_out_valid = 1'b1;
            n_value_res = w_data[0];
            n_status    = ST_OK;
            n_last      = disp_last;
            n_disp      = r_disp + 1'b1;
            if (disp_last) begin
                n_state = S_IDLE;
            end
            for (int i = 0; i < CAPACITY; i++) begin
                if (CW'(i + 1) < r_count) begin
                    w_op[i] = CELL_SHIFT;
                end else if (CW'(i + 1) == r_count) begin
                    w_op[i] = CELL_WRAP;
                end
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g < CAPACITY - 1) begin : g_mid
            assign w_next[g] = w_data[g + 1];
        end else begin : g_end
            assign w_next[g] = '0;
        end

        ble_cell u_cell (
            .i_clk  (i_clk),
            .i_op   (w_op[g]),
            .i_new  (i_value),
            .i_next (w_next[g]),
            .i_head (w_data[0]),
            .o_data (w_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_disp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_disp      <= n_disp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value_res <= n_value_res;
        r_status    <= n_status;
        r_last      <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_value_res = r_value_res;
    assign o_status    = r_status;
    assign o_last      = r_last;

    `BLE_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "entry count above capacity")
    `BLE_ASSERT_IMPL(a_disp_blocks, r_state == S_DISP, o_in_stall, "request taken during display")
    `BLE_ASSERT_NEXT(a_full_report,
        accept && (i_action == ACT_INSERT) && (r_count == CW'(CAPACITY)),
        o_out_valid && (o_status == ST_FULL) && (r_count == CW'(CAPACITY)),
        "insert into full list not reported")
    `BLE_ASSERT_NEXT(a_disp_end,
        (r_state == S_DISP) && out_free && disp_last,
        (r_state == S_IDLE) && o_out_valid && o_last,
        "display did not end on last entry")

endmodule

### hw/rtl/ble_cell.sv
module ble_cell
    import ble_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_op                 i_op,
    input  logic signed [DATA_W-1:0] i_new,
    input  logic signed [DATA_W-1:0] i_next,
    input  logic signed [DATA_W-1:0] i_head,
    output logic signed [DATA_W-1:0] o_data
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        case (i_op)
            CELL_LOAD:  n_data = i_new;
            CELL_SHIFT: n_data = i_next;
            CELL_WRAP:  n_data = i_head;
            default:    n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import ble_pkg::*;

    localparam int CAPACITY = 16;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic                     is_last;
    } t_list_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [2:0]               i_action;
    logic signed [DATA_W-1:0] i_value;
    logic [7:0]               i_position;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [DATA_W-1:0] o_value_res;
    logic [1:0]               o_status;
    logic                     o_last;

    logic signed [DATA_W-1:0] list_vals [CAPACITY];
    int                       list_count;
    t_list_result             pending_results [$];
    int                       fail_count;
    int                       quiet_cycles;
    bit                       gaps_enabled;

    bounded_list_engine_core #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_action(i_action),
        .i_value(i_value),
        .i_position(i_position),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_value_res(o_value_res),
        .o_status(o_status),
        .o_last(o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void queue_result(logic signed [DATA_W-1:0] value, t_status status,
                                         logic is_last);
        t_list_result r;
        r.value = value;
        r.status = status;
        r.is_last = is_last;
        pending_results.push_back(r);
    endfunction

    function automatic logic signed [DATA_W-1:0] remove_entry(int idx);
        logic signed [DATA_W-1:0] v;
        v = list_vals[idx];
        for (int i = idx; i < list_count - 1; i++)
            list_vals[i] = list_vals[i + 1];
        list_count--;
        return v;
    endfunction

    function automatic void apply_list_action(logic [2:0] act, logic signed [DATA_W-1:0] val,
                                              logic [7:0] pos);
        case (act)
            ACT_INSERT: begin
                if (list_count >= CAPACITY) begin
                    queue_result(0, ST_FULL, 1'b1);
                end else begin
                    list_vals[list_count] = val;
                    list_count++;
                    queue_result(0, ST_OK, 1'b1);
                end
            end
            ACT_DEL_FRONT: begin
                if (list_count == 0) queue_result(0, ST_EMPTY, 1'b1);
                else queue_result(remove_entry(0), ST_OK, 1'b1);
            end
            ACT_DEL_BACK: begin
                if (list_count == 0) queue_result(0, ST_EMPTY, 1'b1);
                else queue_result(remove_entry(list_count - 1), ST_OK, 1'b1);
            end
            ACT_DEL_POS: begin
                if (list_count == 0) queue_result(0, ST_EMPTY, 1'b1);
                else if (pos < 1 || pos > list_count) queue_result(0, ST_BADPOS, 1'b1);
                else queue_result(remove_entry(pos - 1), ST_OK, 1'b1);
            end
            ACT_DISPLAY: begin
                if (list_count == 0) begin
                    queue_result(0, ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < list_count; i++)
                        queue_result(list_vals[i], ST_OK, (i == list_count - 1));
                end
            end
            default: ;
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic push_request(logic [2:0] act, logic signed [DATA_W-1:0] val,
                                logic [7:0] pos);
        if (gaps_enabled && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_action <= act;
        i_value <= val;
        i_position <= pos;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        apply_list_action(act, val, pos);
        @(negedge i_clk);
    endtask

    task automatic test_empty_list();
        push_request(ACT_DISPLAY, $urandom, 8'($urandom));
        push_request(ACT_DEL_FRONT, $urandom, 8'($urandom));
        push_request(ACT_DEL_BACK, $urandom, 8'($urandom));
        push_request(ACT_DEL_POS, $urandom, 8'd0);
        push_request(ACT_DEL_POS, $urandom, 8'd1);
        for (int a = 5; a < 8; a++)
            push_request(a[2:0], $urandom, 8'($urandom));
    endtask

    task automatic test_fill_and_overflow();
        push_request(ACT_INSERT, 32'sh8000_0000, 8'hff);
        push_request(ACT_INSERT, 32'sh7fff_ffff, 8'h00);
        push_request(ACT_INSERT, 32'sh0000_0000, 8'($urandom));
        push_request(ACT_INSERT, -32'sd1, 8'($urandom));
        while (list_count < CAPACITY)
            push_request(ACT_INSERT, $urandom, 8'($urandom));
        push_request(ACT_INSERT, $urandom, 8'($urandom));
        push_request(ACT_DISPLAY, $urandom, 8'($urandom));
    endtask

    task automatic test_position_edges();
        push_request(ACT_DEL_POS, $urandom, 8'd0);
        push_request(ACT_DEL_POS, $urandom, 8'd255);
        push_request(ACT_DEL_POS, $urandom, 8'(list_count + 1));
        push_request(ACT_DEL_POS, $urandom, 8'(list_count));
        push_request(ACT_DEL_POS, $urandom, 8'd1);
        push_request(ACT_DEL_POS, $urandom, 8'd5);
        push_request(ACT_DEL_FRONT, $urandom, 8'($urandom));
        push_request(ACT_DEL_BACK, $urandom, 8'($urandom));
        push_request(ACT_DISPLAY, $urandom, 8'($urandom));
    endtask

    // grow_weight: percent of requests that are inserts
    task automatic test_random_traffic(int n, int grow_weight);
        int done;
        int r;
        logic [2:0] act;
        logic signed [DATA_W-1:0] val;
        logic [7:0] pos;
        done = 0;
        while (done < n) begin
            r = $urandom_range(0, 99);
            if (r < grow_weight) act = ACT_INSERT;
            else if (r < 92) act = 3'($urandom_range(ACT_DEL_FRONT, ACT_DEL_POS));
            else if (r < 97) act = ACT_DISPLAY;
            else act = 3'($urandom_range(5, 7));
            case ($urandom_range(0, 9))
                0: val = 32'sh8000_0000;
                1: val = 32'sh7fff_ffff;
                default: val = $urandom;
            endcase
            if ($urandom_range(0, 4) == 0 || list_count == 0)
                pos = 8'($urandom_range(0, 255));
            else
                pos = 8'($urandom_range(1, list_count));
            push_request(act, val, pos);
            if (act <= ACT_DISPLAY) done++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: value_res %0d status %0d last %0d",
                       o_value_res, o_status, o_last);
                fail_count++;
            end else begin
                t_list_result exp_r;
                exp_r = pending_results.pop_front();
                if (o_value_res !== exp_r.value) begin
                    $error("value_res mismatch: expected %0d, got %0d", exp_r.value, o_value_res);
                    fail_count++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status mismatch: expected %0d, got %0d", exp_r.status, o_status);
                    fail_count++;
                end
                if (o_last !== exp_r.is_last) begin
                    $error("last mismatch: expected %0d, got %0d", exp_r.is_last, o_last);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall bursts
    always begin
        @(negedge i_clk);
        if (gaps_enabled && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = ACT_INSERT;
        i_value = '0;
        i_position = '0;
        i_out_stall = 1'b0;
        list_count = 0;
        gaps_enabled = 1'b1;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_list();
        test_fill_and_overflow();
        test_position_edges();
        test_random_traffic(90, 70);
        test_random_traffic(90, 25);
        test_random_traffic(110, 50);
        gaps_enabled = 1'b0;
        test_random_traffic(70, 50);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### bounded_list_engine_core.f
+incdir+hw/rtl
hw/rtl/ble_pkg.sv
hw/rtl/ble_cell.sv
hw/rtl/bounded_list_engine_core.sv
tb/tb.sv
